// ----- sv/bhds_pkg.sv -----
// ----------------------------------------------------------------------------
// bhds_pkg
// Shared types, constants and SHA-256 helpers for the header hash check.
// ----------------------------------------------------------------------------
package bhds_pkg;

    localparam int HDR_BITS   = 640;
    localparam int DIG_BITS   = 256;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] REG_TARGET3 = 2'd0;
    localparam logic [1:0] REG_TARGET2 = 2'd1;
    localparam logic [1:0] REG_TARGET1 = 2'd2;
    localparam logic [1:0] REG_TARGET0 = 2'd3;

    typedef logic [HDR_BITS-1:0] header_t;
    typedef logic [DIG_BITS-1:0] digest_t;

    // one job handed from front to back
    typedef struct packed {
        header_t     hdr;
        logic [31:0] nonce;
    } job_t;

    localparam logic [255:0] INIT_H = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] bswap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic logic [63:0] bswap64(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[8*i +: 8] = x[56-8*i +: 8];
        end
        return r;
    endfunction

endpackage

// ----- sv/bhds_front.sv -----
// ----------------------------------------------------------------------------
// bhds_front
// Accepts header items, assembles the 80-byte wire header, queues jobs.
// ----------------------------------------------------------------------------
module bhds_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [31:0]     version_word,
    input  logic [63:0]     prev_hash_a,
    input  logic [63:0]     prev_hash_b,
    input  logic [63:0]     prev_hash_c,
    input  logic [63:0]     prev_hash_d,
    input  logic [63:0]     merkle_a,
    input  logic [63:0]     merkle_b,
    input  logic [63:0]     merkle_c,
    input  logic [63:0]     merkle_d,
    input  logic [31:0]     time_word,
    input  logic [31:0]     bits_word,
    input  logic [31:0]     nonce_value,
    output logic            job_valid,
    input  logic            job_ready,
    output bhds_pkg::job_t  job
);
    import bhds_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    job_t          q_mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;
    job_t          new_job;
    logic          push, pop;

    // header assembly: version, prev hash, time, bits and nonce byte-reversed per 32-bit word, merkle words as given
    always_comb
    begin
        new_job.hdr = {bswap32(version_word),
                       bswap32(prev_hash_a[63:32]), bswap32(prev_hash_a[31:0]),
                       bswap32(prev_hash_b[63:32]), bswap32(prev_hash_b[31:0]),
                       bswap32(prev_hash_c[63:32]), bswap32(prev_hash_c[31:0]),
                       bswap32(prev_hash_d[63:32]), bswap32(prev_hash_d[31:0]),
                       merkle_a, merkle_b, merkle_c, merkle_d,
                       bswap32(time_word), bswap32(bits_word), bswap32(nonce_value)};
        new_job.nonce = nonce_value;
    end

    assign in_ready  = (count_reg != QUEUE_DEPTH[PW:0]);
    assign job_valid = (count_reg != '0);
    assign job       = q_mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = job_valid && job_ready;

    // job queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= new_job;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + {{PW{1'b0}}, push} - {{PW{1'b0}}, pop};
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_DEPTH[PW:0])
        else $error("queue count overflow");
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == QUEUE_DEPTH[PW:0]) |-> !in_ready)
        else $error("full queue accepts item");
    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop count mismatch");

endmodule

// ----- sv/bhds_back.sv -----
// ----------------------------------------------------------------------------
// bhds_back
// Shared SHA-256 round unit: three compressions per job, then compare.
// ----------------------------------------------------------------------------
module bhds_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_valid,
    output logic            job_ready,
    input  bhds_pkg::job_t  job,
    input  logic [255:0]    target,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [63:0]     digest_a,
    output logic [63:0]     digest_b,
    output logic [63:0]     digest_c,
    output logic [63:0]     digest_d,
    output logic            meets_target,
    output logic            new_best
);
    import bhds_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;

    logic [1:0]   state_reg, state_next;
    logic [1:0]   pass_reg;
    logic [5:0]   rnd_reg;
    header_t      hdr_reg;
    logic [31:0]  nonce_reg;
    logic [31:0]  w_reg [16];
    logic [255:0] work_reg;
    logic [255:0] mid_reg;
    logic [255:0] hout_reg;
    logic [255:0] best_reg;
    logic [31:0]  best_nonce_reg;
    logic         out_valid_reg;
    logic         meets_reg, newb_reg;
    logic [255:0] dig_out_reg;

    logic [31:0]  a, b, c, d, e, f, g, h, t1, t2, s0, s1, w_new, wt;
    logic [255:0] chain, sum_h, dig_le, work_next;
    logic         lt_target, lt_best;

    // chaining value of the current pass
    always_comb
    begin
        case (pass_reg)
            2'd0:    chain = INIT_H;
            2'd1:    chain = mid_reg;
            default: chain = INIT_H;
        endcase
    end

    // one round per cycle
    always_comb
    begin
        {a, b, c, d, e, f, g, h} = work_reg;
        s0 = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
             ^ (w_reg[1] >> 3);
        s1 = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
             ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        wt = w_reg[0];
        t1 = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
             + ((e & f) ^ (~e & g)) + round_k(rnd_reg) + wt;
        t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
             + ((a & b) ^ (a & c) ^ (b & c));
        work_next = {t1 + t2, a, b, c, d + t1, e, f, g};
        // chaining add after the last round of a pass
        for (int i = 0; i < 8; i++)
        begin
            sum_h[32*i +: 32] = chain[32*i +: 32] + work_next[32*i +: 32];
        end
    end

    // little-endian view of the digest, whole 256 bits byte-reversed
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            dig_le[64*i +: 64] = bswap64(hout_reg[255-64*i -: 64]);
        end
        lt_target = (dig_le <= target);
        lt_best   = (dig_le < best_reg);
    end

    assign job_ready = (state_reg == ST_IDLE);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (job_valid) state_next = ST_RUN;
            ST_RUN:  if (rnd_reg == 6'd63 && pass_reg == 2'd2) state_next = ST_CMP;
            ST_CMP:  if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pass_reg       <= '0;
            rnd_reg        <= '0;
            out_valid_reg  <= 1'b0;
            best_reg       <= '1;
            best_nonce_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // result register: load on compare, clear when taken
            if (state_reg == ST_CMP && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    pass_reg <= '0;
                    rnd_reg  <= '0;
                end
                ST_RUN:
                begin
                    rnd_reg <= rnd_reg + 1'b1;
                    if (rnd_reg == 6'd63)
                    begin
                        pass_reg <= pass_reg + 1'b1;
                    end
                end
                ST_CMP:
                begin
                    if ((!out_valid_reg || out_ready) && lt_best)
                    begin
                        best_reg       <= dig_le;
                        best_nonce_reg <= nonce_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && job_valid)
        begin
            hdr_reg   <= job.hdr;
            nonce_reg <= job.nonce;
            work_reg  <= INIT_H;
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= job.hdr[639-32*i -: 32];
            end
        end
        else if (state_reg == ST_RUN)
        begin
            if (rnd_reg == 6'd63)
            begin
                // finish pass and load next block, or keep the final hash after the last pass
                case (pass_reg)
                    2'd0:
                    begin
                        work_reg <= sum_h;
                        mid_reg  <= sum_h;
                        for (int i = 0; i < 4; i++)
                        begin
                            w_reg[i] <= hdr_reg[127-32*i -: 32];
                        end
                        w_reg[4] <= 32'h80000000;
                        for (int i = 5; i < 15; i++)
                        begin
                            w_reg[i] <= 32'd0;
                        end
                        w_reg[15] <= 32'd640;
                    end
                    2'd1:
                    begin
                        work_reg <= INIT_H;
                        mid_reg  <= sum_h;
                        for (int i = 0; i < 8; i++)
                        begin
                            w_reg[i] <= sum_h[255-32*i -: 32];
                        end
                        w_reg[8] <= 32'h80000000;
                        for (int i = 9; i < 15; i++)
                        begin
                            w_reg[i] <= 32'd0;
                        end
                        w_reg[15] <= 32'd256;
                    end
                    default: hout_reg <= sum_h;
                endcase
            end
            else
            begin
                work_reg <= work_next;
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i+1];
                end
                w_reg[15] <= w_new;
            end
        end
        else if (state_reg == ST_CMP && (!out_valid_reg || out_ready))
        begin
            dig_out_reg <= hout_reg;
            meets_reg   <= lt_target;
            newb_reg    <= lt_best;
        end
    end

    assign out_valid    = out_valid_reg;
    assign digest_a     = dig_out_reg[255:192];
    assign digest_b     = dig_out_reg[191:128];
    assign digest_c     = dig_out_reg[127:64];
    assign digest_d     = dig_out_reg[63:0];
    assign meets_target = meets_reg;
    assign new_best     = newb_reg;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("result dropped");
    a_best_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (best_reg != $past(best_reg)) |-> (best_reg < $past(best_reg)))
        else $error("best hash grew");
    a_pass_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (pass_reg != 2'd3))
        else $error("pass out of range");

endmodule

// ----- sv/block_header_double_sha256_check.sv -----
// ----------------------------------------------------------------------------
// block_header_double_sha256_check
// Double SHA-256 of a block header, target check and best-hash tracking.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  in      | in_valid / in_ready    | header fields and nonce
//  out     | out_valid / out_ready  | digest, meets_target, new_best
//  cfg     | cfg_we                 | cfg_index, cfg_data (64 bits)
//
//  each item takes three compressions on the shared round unit plus
//  the load and compare steps; that unit sets the rate.
//  a two-entry queue takes new items while the round unit is busy.
//  reset clears targets and best hash to all ones, best nonce to zero.
// ----------------------------------------------------------------------------
module block_header_double_sha256_check (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] version_word,
    input  logic [63:0] prev_hash_a,
    input  logic [63:0] prev_hash_b,
    input  logic [63:0] prev_hash_c,
    input  logic [63:0] prev_hash_d,
    input  logic [63:0] merkle_a,
    input  logic [63:0] merkle_b,
    input  logic [63:0] merkle_c,
    input  logic [63:0] merkle_d,
    input  logic [31:0] time_word,
    input  logic [31:0] bits_word,
    input  logic [31:0] nonce_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_a,
    output logic [63:0] digest_b,
    output logic [63:0] digest_c,
    output logic [63:0] digest_d,
    output logic        meets_target,
    output logic        new_best
);
    import bhds_pkg::*;

    logic [255:0] target_reg;
    logic         job_valid, job_ready;
    job_t         job;

    // target registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TARGET3: target_reg[255:192] <= cfg_data;
                REG_TARGET2: target_reg[191:128] <= cfg_data;
                REG_TARGET1: target_reg[127:64]  <= cfg_data;
                REG_TARGET0: target_reg[63:0]    <= cfg_data;
                default: ;
            endcase
        end
    end

    bhds_front u_front (
        .clk, .rst_n, .in_valid, .in_ready,
        .version_word, .prev_hash_a, .prev_hash_b, .prev_hash_c, .prev_hash_d,
        .merkle_a, .merkle_b, .merkle_c, .merkle_d,
        .time_word, .bits_word, .nonce_value,
        .job_valid, .job_ready, .job
    );

    bhds_back u_back (
        .clk, .rst_n, .job_valid, .job_ready, .job,
        .target(target_reg),
        .out_valid, .out_ready,
        .digest_a, .digest_b, .digest_c, .digest_d,
        .meets_target, .new_best
    );

endmodule
